// ----- rtl/cts_pkg.sv -----
package cts_pkg;

    localparam int WAYS      = 8;
    localparam int WAY_W     = 3;
    localparam int WAY_OUT_W = 4;
    localparam int TAG_IN_W  = 32;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 40;

    localparam logic [WAY_OUT_W-1:0] WAY_NONE = 4'd8;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FILL   = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef logic [WAYS-1:0][WAY_W-1:0] t_order;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0] dirty;
        logic [WAYS-1:0] resv;
        t_order          order;
    } t_row;

    typedef struct packed {
        t_op                 op;
        logic [TAG_IN_W-1:0] tag;
        logic                is_write;
        logic [WAY_W-1:0]    way;
    } t_item;

    typedef struct packed {
        logic                 success;
        logic [WAY_OUT_W-1:0] way_out;
        logic                 wb;
        logic [TAG_IN_W-1:0]  wb_tag;
        logic                 misuse;
    } t_result;

    // way 0 least recent at position 0
    localparam t_row ROW_RESET = '{
        valid: '0,
        dirty: '0,
        resv:  '0,
        order: 24'o76543210
    };

    function automatic t_order make_recent(t_order ord, logic [WAY_W-1:0] w);
        logic [WAY_W-1:0] pos;
        t_order           res;
        pos = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (ord[i] == w) begin
                pos = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS - 1; i++) begin
            res[i] = (WAY_W'(i) < pos) ? ord[i] : ord[i+1];
        end
        res[WAYS-1] = w;
        return res;
    endfunction

endpackage

// ----- rtl/cts_ram.sv -----
module cts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cts_update.sv -----
module cts_update #(
    parameter int TW = 32
) (
    input  cts_pkg::t_item                      i_item,
    input  logic                                i_wt,
    input  cts_pkg::t_row                       i_row,
    input  logic [cts_pkg::WAYS-1:0][TW-1:0]    i_tags,
    output cts_pkg::t_row                       o_row,
    output logic [cts_pkg::WAYS-1:0][TW-1:0]    o_tags,
    output cts_pkg::t_result                    o_res
);

    logic [cts_pkg::WAYS-1:0]  hit;
    logic [cts_pkg::WAY_W-1:0] hit_way;
    logic                      found;
    logic [cts_pkg::WAY_W-1:0] vic_way;
    logic [cts_pkg::WAY_W-1:0] way;

    assign way = i_item.way;

    // lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = 0; w < cts_pkg::WAYS; w++) begin
            hit[w] = i_row.valid[w] && !i_row.resv[w] && (i_tags[w] == i_item.tag[TW-1:0]);
        end
        for (int w = cts_pkg::WAYS - 1; w >= 0; w--) begin
            if (hit[w]) begin
                hit_way = cts_pkg::WAY_W'(w);
            end
        end
    end

    // least recent unreserved way
    always_comb begin
        found   = 1'b0;
        vic_way = '0;
        for (int i = 0; i < cts_pkg::WAYS; i++) begin
            if (!found && !i_row.resv[i_row.order[i]]) begin
                found   = 1'b1;
                vic_way = i_row.order[i];
            end
        end
    end

    always_comb begin
        o_row         = i_row;
        o_tags        = i_tags;
        o_res         = '0;
        o_res.way_out = cts_pkg::WAY_NONE;
        case (i_item.op)
            cts_pkg::OP_LOOKUP: begin
                if (|hit) begin
                    o_res.success = 1'b1;
                    o_res.way_out = {1'b0, hit_way};
                    if (i_item.is_write && !i_wt) begin
                        o_row.dirty[hit_way] = 1'b1;
                    end
                    o_row.order = cts_pkg::make_recent(i_row.order, hit_way);
                end
            end
            cts_pkg::OP_ALLOC: begin
                if (found) begin
                    o_res.success = 1'b1;
                    o_res.way_out = {1'b0, vic_way};
                    if (i_row.valid[vic_way] && i_row.dirty[vic_way]) begin
                        o_res.wb     = 1'b1;
                        o_res.wb_tag = cts_pkg::TAG_IN_W'(i_tags[vic_way]);
                    end
                    o_row.valid[vic_way] = 1'b0;
                    o_row.dirty[vic_way] = 1'b0;
                    o_row.resv[vic_way]  = 1'b1;
                end
            end
            cts_pkg::OP_FILL: begin
                if (i_row.resv[way]) begin
                    o_tags[way]      = i_item.tag[TW-1:0];
                    o_row.valid[way] = 1'b1;
                    o_row.dirty[way] = 1'b0;
                    o_row.resv[way]  = 1'b0;
                    o_row.order      = cts_pkg::make_recent(i_row.order, way);
                    o_res.success    = 1'b1;
                    o_res.way_out    = {1'b0, way};
                end else begin
                    o_res.misuse = 1'b1;
                end
            end
            cts_pkg::OP_FLUSH: begin
                if (i_row.valid[way] && i_row.dirty[way]) begin
                    o_res.wb     = 1'b1;
                    o_res.wb_tag = cts_pkg::TAG_IN_W'(i_tags[way]);
                end
                o_tags[way]      = '0;
                o_row.valid[way] = 1'b0;
                o_row.dirty[way] = 1'b0;
                if (!i_row.resv[way]) begin
                    o_row.order = cts_pkg::make_recent(i_row.order, way);
                end
                o_res.success = 1'b1;
                o_res.way_out = {1'b0, way};
            end
            default: begin
                o_res.way_out = cts_pkg::WAY_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/cache_tag_store_lru.sv -----
// channel    | dir | handshake                      | payload
// -----------+-----+--------------------------------+----------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready  | op, set_index, tag, is_write, way
// m_axis     | out | m_axis_tvalid / m_axis_tready  | success, way_out, needs_writeback,
//            |     |                                | writeback_tag, misuse
// cfg        | in  | i_cfg_valid / o_cfg_ready      | write_through
//
// one request per cycle sustained while results are drained; each request is registered into the work stage,
// the set and tag rams being read on the accepting edge in step with the input register
// a request to the set written by the request just ahead is served from a forwarding copy
// reset clears control flops and one row-valid flag per set; a set never written reads as
// all invalid, unreserved, ways in reset recency order, so no clearing pass is needed
// a stalled result holds the pipeline: s_axis_tready drops only when both the result
// register and the work stage are full
module cache_tag_store_lru #(
    parameter int SETS     = 64,   // power of two
    parameter int TAG_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // op[1:0], set_index[7:2], tag[39:8], is_write[40], way[43:41], zero[47:44]
    input  logic [cts_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // success[0], way_out[4:1], needs_writeback[5], writeback_tag[37:6], misuse[38], zero[39]
    output logic [cts_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [0:0]                 i_cfg_data
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_W = (SET_W > 6) ? SET_W : 6;
    localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int ROW_W = $bits(cts_pkg::t_row);
    localparam int TAG_W = cts_pkg::WAYS * TW;

    // input decode
    cts_pkg::t_item   in_item;
    logic [IDX_W-1:0] in_idx;
    logic [SET_W-1:0] in_set;
    logic             acc_in;

    // work stage
    logic             r_s1_v;
    cts_pkg::t_item   r_s1_item;
    logic [SET_W-1:0] r_s1_set;
    logic             adv;

    // forwarding copy of the last written set
    logic                                r_fwd;
    cts_pkg::t_row                       r_fwd_row;
    logic [cts_pkg::WAYS-1:0][TW-1:0]    r_fwd_tags;

    // per-set row-valid flags
    logic [SETS-1:0] r_rowv;

    logic            r_wt;
    logic            r_out_v;
    cts_pkg::t_result r_out;

    logic [ROW_W-1:0]                    rd_row;
    logic [TAG_W-1:0]                    rd_tags;
    cts_pkg::t_row                       cur_row;
    logic [cts_pkg::WAYS-1:0][TW-1:0]    cur_tags;
    cts_pkg::t_row                       n_row;
    logic [cts_pkg::WAYS-1:0][TW-1:0]    n_tags;
    cts_pkg::t_result                    n_res;

    assign in_item.op       = cts_pkg::t_op'(s_axis_tdata[1:0]);
    assign in_item.tag      = s_axis_tdata[39:8];
    assign in_item.is_write = s_axis_tdata[40];
    assign in_item.way      = s_axis_tdata[43:41];
    assign in_idx           = IDX_W'(s_axis_tdata[7:2]);
    assign in_set           = in_idx[SET_W-1:0] & SET_W'(SETS - 1);

    // stage moves on when the result register is free or being drained
    assign adv           = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || adv;
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    cts_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_s1_set),
        .i_wdata (n_row),
        .i_re    (acc_in),
        .i_raddr (in_set),
        .o_rdata (rd_row)
    );

    cts_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_s1_set),
        .i_wdata (n_tags),
        .i_re    (acc_in),
        .i_raddr (in_set),
        .o_rdata (rd_tags)
    );

    // ram read missed the write that landed on the same edge: take the forwarding copy
    always_comb begin
        if (r_fwd) begin
            cur_row  = r_fwd_row;
            cur_tags = r_fwd_tags;
        end else begin
            cur_row  = r_rowv[r_s1_set] ? cts_pkg::t_row'(rd_row) : cts_pkg::ROW_RESET;
            cur_tags = rd_tags;
        end
    end

    cts_update #(
        .TW (TW)
    ) u_update (
        .i_item (r_s1_item),
        .i_wt   (r_wt),
        .i_row  (cur_row),
        .i_tags (cur_tags),
        .o_row  (n_row),
        .o_tags (n_tags),
        .o_res  (n_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd   <= 1'b0;
            r_rowv  <= '0;
            r_wt    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wt <= i_cfg_data[0];
            end
            if (acc_in) begin
                r_s1_v <= 1'b1;
                r_fwd  <= adv && (r_s1_set == in_set);
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
            if (adv) begin
                r_rowv[r_s1_set] <= 1'b1;
                r_out_v          <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_item <= in_item;
            r_s1_set  <= in_set;
        end
        if (adv) begin
            r_fwd_row  <= n_row;
            r_fwd_tags <= n_tags;
            r_out      <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {1'b0, r_out.misuse, r_out.wb_tag, r_out.wb,
                            r_out.way_out, r_out.success};

endmodule

// ----- rtl/cts_checker.sv -----
module cts_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_m_tvalid,
    input logic                      i_m_tready,
    input logic [cts_pkg::OUT_W-1:0] i_m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    // nothing pending comes out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // a rejected fill reports no way, no success and no write-back
    a_misuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[38] |->
            !i_m_tdata[0] && (i_m_tdata[4:1] == cts_pkg::WAY_NONE) && !i_m_tdata[5])
        else $error("misuse with success or way");

    // write-back only on success, tag zero otherwise
    a_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[5] ? i_m_tdata[0] : (i_m_tdata[37:6] == '0)))
        else $error("bad write-back report");

    // way field set exactly on success
    a_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[0] == (i_m_tdata[4:1] != cts_pkg::WAY_NONE))
            && !i_m_tdata[4] || (i_m_tdata[4:1] == cts_pkg::WAY_NONE && !i_m_tdata[0]))
        else $error("way field inconsistent with success");

endmodule

bind cache_tag_store_lru cts_checker u_cts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
